### src/upoc_pkg.sv
// Shared types, constants and the CORDIC angle table for the point offset control unit.
package upoc_pkg;

    localparam int CORDIC_STAGES = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0]  REG_GAIN       = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_INV_OFFSET = 1'd1;
    localparam logic [CFG_DATA_W-1:0] GAIN_RST       = 16'd256;
    localparam logic [CFG_DATA_W-1:0] INV_OFFSET_RST = 16'd256;

    localparam int ERR_W     = 33;
    localparam int GAIN_FRAC = 8;
    localparam int VEL_W     = 41;
    localparam int ANG_W     = 33;
    localparam int CRD_W     = 33;
    localparam int TRIG_W    = 18;
    localparam int TRIG_SHR  = 14;

    localparam logic signed [CRD_W-1:0] CORDIC_X0 = 33'sd652032874;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
    } upoc_in_t;

    typedef struct packed {
        logic signed [31:0] forward_speed;
        logic signed [31:0] turn_rate;
    } upoc_out_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
    } upoc_vel_t;

    function automatic logic signed [ANG_W-1:0] atan_step(input int idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            0:       r = 33'sd536870912;
            1:       r = 33'sd316933406;
            2:       r = 33'sd167458907;
            3:       r = 33'sd85004756;
            4:       r = 33'sd42667331;
            5:       r = 33'sd21354465;
            6:       r = 33'sd10679838;
            7:       r = 33'sd5340245;
            8:       r = 33'sd2670163;
            9:       r = 33'sd1335087;
            10:      r = 33'sd667544;
            11:      r = 33'sd333772;
            12:      r = 33'sd166886;
            13:      r = 33'sd83443;
            14:      r = 33'sd41722;
            15:      r = 33'sd20861;
            16:      r = 33'sd10430;
            17:      r = 33'sd5215;
            18:      r = 33'sd2608;
            19:      r = 33'sd1304;
            20:      r = 33'sd652;
            21:      r = 33'sd326;
            22:      r = 33'sd163;
            23:      r = 33'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### src/upoc_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, velocity carried alongside.
module upoc_cordic
    import upoc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [ANG_W-1:0]  in_angle,
    input  logic                     in_neg,
    input  upoc_vel_t                in_vel,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [TRIG_W-1:0] out_cos,
    output logic signed [TRIG_W-1:0] out_sin,
    output upoc_vel_t                out_vel
);

    localparam int N = CORDIC_STAGES;

    logic [N-1:0]            v_reg;
    logic [N-1:0]            neg_reg;
    logic signed [CRD_W-1:0] x_reg   [N];
    logic signed [CRD_W-1:0] y_reg   [N];
    logic signed [ANG_W-1:0] z_reg   [N];
    upoc_vel_t               vel_reg [N];

    logic [N-1:0]            v_src;
    logic [N-1:0]            neg_src;
    logic signed [CRD_W-1:0] x_src   [N];
    logic signed [CRD_W-1:0] y_src   [N];
    logic signed [ANG_W-1:0] z_src   [N];
    upoc_vel_t               vel_src [N];

    logic signed [CRD_W-1:0] x_next  [N];
    logic signed [CRD_W-1:0] y_next  [N];
    logic signed [ANG_W-1:0] z_next  [N];
    logic [N:0]              rdy;

    assign rdy[N]   = out_ready;
    assign in_ready = rdy[0];

    for (genvar i = 0; i < N; i++) begin : g_stage
        if (i == 0) begin : g_first
            assign v_src[i]   = in_valid;
            assign neg_src[i] = in_neg;
            assign x_src[i]   = CORDIC_X0;
            assign y_src[i]   = '0;
            assign z_src[i]   = in_angle;
            assign vel_src[i] = in_vel;
        end else begin : g_next
            assign v_src[i]   = v_reg[i-1];
            assign neg_src[i] = neg_reg[i-1];
            assign x_src[i]   = x_reg[i-1];
            assign y_src[i]   = y_reg[i-1];
            assign z_src[i]   = z_reg[i-1];
            assign vel_src[i] = vel_reg[i-1];
        end

        // rotate toward zero residual angle
        assign x_next[i] = !z_src[i][ANG_W-1] ? x_src[i] - (y_src[i] >>> i)
                                              : x_src[i] + (y_src[i] >>> i);
        assign y_next[i] = !z_src[i][ANG_W-1] ? y_src[i] + (x_src[i] >>> i)
                                              : y_src[i] - (x_src[i] >>> i);
        assign z_next[i] = !z_src[i][ANG_W-1] ? z_src[i] - atan_step(i)
                                              : z_src[i] + atan_step(i);
        assign rdy[i]    = !v_reg[i] || rdy[i+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < N; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_src[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            if (rdy[i]) begin
                neg_reg[i] <= neg_src[i];
                x_reg[i]   <= x_next[i];
                y_reg[i]   <= y_next[i];
                z_reg[i]   <= z_next[i];
                vel_reg[i] <= vel_src[i];
            end
        end
    end

    logic signed [CRD_W-1:0]  x_sh;
    logic signed [CRD_W-1:0]  y_sh;
    logic signed [TRIG_W-1:0] cos_raw;
    logic signed [TRIG_W-1:0] sin_raw;

    assign x_sh    = x_reg[N-1] >>> TRIG_SHR;
    assign y_sh    = y_reg[N-1] >>> TRIG_SHR;
    assign cos_raw = x_sh[TRIG_W-1:0];
    assign sin_raw = y_sh[TRIG_W-1:0];

    // left half plane was folded by a half turn
    assign out_cos   = neg_reg[N-1] ? -cos_raw : cos_raw;
    assign out_sin   = neg_reg[N-1] ? -sin_raw : sin_raw;
    assign out_valid = v_reg[N-1];
    assign out_vel   = vel_reg[N-1];

endmodule

### src/unicycle_point_offset_control_unit.sv
// Top level: error and gain, CORDIC heading rotation, body-frame products and saturation.
// Registered stages in order: A, B, the CORDIC pipeline, then C, D, E, F and G.
// Throughput: one word per cycle; every stage holds its word under back-pressure and
// fills bubbles, so input is refused only when all stages are full and m_ready is low.
// Reset (aresetn low, synchronous) clears all stage valid bits and sets gain and
// inv_offset to 1.0 (Q8.8); datapath registers are not reset.
module unicycle_point_offset_control_unit
    import upoc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  upoc_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output upoc_out_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int LO_W     = 24;
    localparam int PROD_W   = 60;
    localparam int FRAC_W   = 16;
    localparam int FWD_W    = PROD_W - FRAC_W;
    localparam int PLO_W    = TRIG_W + LO_W + 1;
    localparam int PHI_W    = TRIG_W + VEL_W - LO_W;
    localparam int TLO_W    = LO_W + 1 + CFG_DATA_W + 1;
    localparam int THI_W    = FWD_W - LO_W + CFG_DATA_W + 1;
    localparam int TURN_W   = 61;
    localparam int INV_FRAC = 8;
    localparam int PROD_X_W = ERR_W + CFG_DATA_W + 1;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // configuration
    logic [CFG_DATA_W-1:0] gain_reg;
    logic [CFG_DATA_W-1:0] inv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RST;
            inv_reg  <= INV_OFFSET_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GAIN:       gain_reg <= cfg_wdata;
                REG_INV_OFFSET: inv_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage valids and ready chain
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg, g_v_reg;
    logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, f_rdy, g_rdy;
    logic cd_in_ready, cd_out_valid;

    assign g_rdy   = !g_v_reg || m_ready;
    assign f_rdy   = !f_v_reg || g_rdy;
    assign e_rdy   = !e_v_reg || f_rdy;
    assign d_rdy   = !d_v_reg || e_rdy;
    assign c_rdy   = !c_v_reg || d_rdy;
    assign b_rdy   = !b_v_reg || cd_in_ready;
    assign a_rdy   = !a_v_reg || b_rdy;
    assign s_ready = a_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
        end else begin
            if (a_rdy) a_v_reg <= s_valid;
            if (b_rdy) b_v_reg <= a_v_reg;
            if (c_rdy) c_v_reg <= cd_out_valid;
            if (d_rdy) d_v_reg <= c_v_reg;
            if (e_rdy) e_v_reg <= d_v_reg;
            if (f_rdy) f_v_reg <= e_v_reg;
            if (g_rdy) g_v_reg <= f_v_reg;
        end
    end

    // stage A: position error, angle fold
    logic signed [ERR_W-1:0] a_ex_reg, a_ey_reg, a_ex_next, a_ey_next;
    logic signed [ANG_W-1:0] a_z_reg, a_z_next;
    logic                    a_neg_reg, a_neg_next;
    logic [31:0]             ang_raw;

    assign a_ex_next  = {s_data.target_x[31], s_data.target_x}
                      - {s_data.pos_x[31], s_data.pos_x};
    assign a_ey_next  = {s_data.target_y[31], s_data.target_y}
                      - {s_data.pos_y[31], s_data.pos_y};
    assign ang_raw    = {s_data.heading, 16'h0000};
    assign a_neg_next = ang_raw[31] ^ ang_raw[30];
    assign a_z_next   = {ang_raw[31] ^ a_neg_next, ang_raw[31] ^ a_neg_next, ang_raw[30:0]};

    always_ff @(posedge aclk) begin
        if (a_rdy) begin
            a_ex_reg  <= a_ex_next;
            a_ey_reg  <= a_ey_next;
            a_z_reg   <= a_z_next;
            a_neg_reg <= a_neg_next;
        end
    end

    // stage B: velocity = gain * error
    logic signed [PROD_X_W-1:0] prod_x, prod_y;
    logic signed [CFG_DATA_W:0] gain_s;
    upoc_vel_t                  b_vel_reg;
    logic signed [ANG_W-1:0]    b_z_reg;
    logic                       b_neg_reg;

    assign gain_s = $signed({1'b0, gain_reg});
    assign prod_x = a_ex_reg * gain_s;
    assign prod_y = a_ey_reg * gain_s;

    always_ff @(posedge aclk) begin
        if (b_rdy) begin
            b_vel_reg.vx <= prod_x[VEL_W+GAIN_FRAC-1:GAIN_FRAC];
            b_vel_reg.vy <= prod_y[VEL_W+GAIN_FRAC-1:GAIN_FRAC];
            b_z_reg      <= a_z_reg;
            b_neg_reg    <= a_neg_reg;
        end
    end

    // heading sine and cosine
    logic signed [TRIG_W-1:0] cd_cos, cd_sin;
    upoc_vel_t                cd_vel;

    upoc_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b_v_reg),
        .in_ready  (cd_in_ready),
        .in_angle  (b_z_reg),
        .in_neg    (b_neg_reg),
        .in_vel    (b_vel_reg),
        .out_valid (cd_out_valid),
        .out_ready (c_rdy),
        .out_cos   (cd_cos),
        .out_sin   (cd_sin),
        .out_vel   (cd_vel)
    );

    // stage C: split products, velocity cut at LO_W bits
    logic signed [LO_W:0]          vx_lo, vy_lo;
    logic signed [VEL_W-LO_W-1:0]  vx_hi, vy_hi;
    logic signed [PLO_W-1:0]       c_cxl_reg, c_syl_reg, c_cyl_reg, c_sxl_reg;
    logic signed [PHI_W-1:0]       c_cxh_reg, c_syh_reg, c_cyh_reg, c_sxh_reg;

    assign vx_lo = $signed({1'b0, cd_vel.vx[LO_W-1:0]});
    assign vy_lo = $signed({1'b0, cd_vel.vy[LO_W-1:0]});
    assign vx_hi = cd_vel.vx[VEL_W-1:LO_W];
    assign vy_hi = cd_vel.vy[VEL_W-1:LO_W];

    always_ff @(posedge aclk) begin
        if (c_rdy) begin
            c_cxl_reg <= cd_cos * vx_lo;
            c_cxh_reg <= cd_cos * vx_hi;
            c_syl_reg <= cd_sin * vy_lo;
            c_syh_reg <= cd_sin * vy_hi;
            c_cyl_reg <= cd_cos * vy_lo;
            c_cyh_reg <= cd_cos * vy_hi;
            c_sxl_reg <= cd_sin * vx_lo;
            c_sxh_reg <= cd_sin * vx_hi;
        end
    end

    // stage D: recombine partial products
    logic signed [PROD_W-1:0] d_cx_reg, d_sy_reg, d_cy_reg, d_sx_reg;

    always_ff @(posedge aclk) begin
        if (d_rdy) begin
            d_cx_reg <= (PROD_W'(c_cxh_reg) <<< LO_W) + PROD_W'(c_cxl_reg);
            d_sy_reg <= (PROD_W'(c_syh_reg) <<< LO_W) + PROD_W'(c_syl_reg);
            d_cy_reg <= (PROD_W'(c_cyh_reg) <<< LO_W) + PROD_W'(c_cyl_reg);
            d_sx_reg <= (PROD_W'(c_sxh_reg) <<< LO_W) + PROD_W'(c_sxl_reg);
        end
    end

    // stage E: body-frame velocity
    logic signed [PROD_W-1:0] fwd_full, lat_full;
    logic signed [FWD_W-1:0]  e_fwd_reg, e_lat_reg;

    assign fwd_full = d_cx_reg + d_sy_reg;
    assign lat_full = d_cy_reg - d_sx_reg;

    always_ff @(posedge aclk) begin
        if (e_rdy) begin
            e_fwd_reg <= fwd_full[PROD_W-1:FRAC_W];
            e_lat_reg <= lat_full[PROD_W-1:FRAC_W];
        end
    end

    // stage F: lateral times inverse offset, forward saturate
    logic signed [LO_W:0]         lat_lo;
    logic signed [FWD_W-LO_W-1:0] lat_hi;
    logic signed [CFG_DATA_W:0]   inv_s;
    logic signed [TLO_W-1:0]      f_tl_reg;
    logic signed [THI_W-1:0]      f_th_reg;
    logic [31:0]                  f_fwd_reg;

    assign lat_lo = $signed({1'b0, e_lat_reg[LO_W-1:0]});
    assign lat_hi = e_lat_reg[FWD_W-1:LO_W];
    assign inv_s  = $signed({1'b0, inv_reg});

    always_ff @(posedge aclk) begin
        if (f_rdy) begin
            f_tl_reg  <= lat_lo * inv_s;
            f_th_reg  <= lat_hi * inv_s;
            f_fwd_reg <= sat32(64'(e_fwd_reg));
        end
    end

    // stage G: output register
    logic signed [TURN_W-1:0] turn_full;
    upoc_out_t                g_data_reg;

    assign turn_full = (TURN_W'(f_th_reg) <<< LO_W) + TURN_W'(f_tl_reg);

    always_ff @(posedge aclk) begin
        if (g_rdy) begin
            g_data_reg.forward_speed <= f_fwd_reg;
            g_data_reg.turn_rate     <= sat32(64'($signed(turn_full[TURN_W-1:INV_FRAC])));
        end
    end

    assign m_valid = g_v_reg;
    assign m_data  = g_data_reg;

    // input is refused only when the output stalls and all stages are full
    a_stall_only_on_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input refused without output back-pressure");

    a_last_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (f_v_reg && g_rdy) |=> m_valid)
        else $error("word lost between last stage and output register");

    a_first_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_v_reg && !a_rdy) |=> (a_v_reg && $stable(a_ex_reg) && $stable(a_z_reg)))
        else $error("stalled first stage changed");

endmodule
